// ===== rtl/bpa_pkg.sv =====
// Shared widths, codes and controller/datapath command types for the bitmap page allocator.
package bpa_pkg;

	// Fixed field widths
	localparam int ADDR_W     = 32;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 13;
	localparam int PCOUNT_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Default build parameters
	localparam int DEF_MAX_PAGES  = 4096;
	localparam int DEF_WORD_BITS  = 32;
	localparam int DEF_PAGE_SHIFT = 12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 2'd2;

	// Configuration reset values
	localparam logic [ADDR_W-1:0]   RST_MEMORY_BASE    = 32'd0;
	localparam logic [PCOUNT_W-1:0] RST_PAGE_COUNT     = 13'd4096;
	localparam logic [PCOUNT_W-1:0] RST_RESERVED_PAGES = 13'd32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

	// Datapath actions issued by the controller
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CAPTURE,
		ACT_INIT_WORD,
		ACT_SCAN_RD,
		ACT_SCAN_NEXT,
		ACT_ALLOC_TAKE,
		ACT_ALLOC_NONE,
		ACT_FREE_SUB,
		ACT_FREE_DIV,
		ACT_FREE_RD,
		ACT_FREE_UPD
	} dp_act_t;

	typedef struct packed {
		dp_act_t act;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic word_hit;
		logic word_last;
	} dp_stat_t;

endpackage

// ===== rtl/bpa_if.sv =====
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if;
	import bpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, output op, output page_address, input ready);
	modport sink (input valid, input op, input page_address, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  free_count;

	modport source (output valid, output result_address, output status, output free_count,
		input ready);
	modport sink (input valid, input result_address, input status, input free_count,
		output ready);
endinterface

// ===== rtl/bpa_ctrl.sv =====
// Controller state machine of the bitmap page allocator.
module bpa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [bpa_pkg::OP_W-1:0]  in_op,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpa_pkg::dp_cmd_t          cmd,
	input  bpa_pkg::dp_stat_t         stat
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FREE_SUB,
		S_FREE_DIV,
		S_FREE_RD,
		S_FREE_UPD,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '{act: ACT_NONE, load_out: 1'b0};
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = ACT_CAPTURE;
					case (in_op)
						OP_INIT:  state_d = S_INIT;
						OP_ALLOC: state_d = S_SCAN_RD;
						OP_FREE:  state_d = S_FREE_SUB;
						default:  state_d = S_RESP;
					endcase
				end
			end
			S_INIT: begin
				cmd.act = ACT_INIT_WORD;
				if (stat.word_last) begin
					state_d = S_RESP;
				end
			end
			S_SCAN_RD: begin
				cmd.act = ACT_SCAN_RD;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (stat.word_hit) begin
					cmd.act = ACT_ALLOC_TAKE;
					state_d = S_RESP;
				end else if (stat.word_last) begin
					cmd.act = ACT_ALLOC_NONE;
					state_d = S_RESP;
				end else begin
					cmd.act = ACT_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_FREE_SUB: begin
				cmd.act = ACT_FREE_SUB;
				state_d = S_FREE_DIV;
			end
			S_FREE_DIV: begin
				cmd.act = ACT_FREE_DIV;
				state_d = S_FREE_RD;
			end
			S_FREE_RD: begin
				cmd.act = ACT_FREE_RD;
				state_d = S_FREE_UPD;
			end
			S_FREE_UPD: begin
				cmd.act = ACT_FREE_UPD;
				state_d = S_RESP;
			end
			S_RESP: begin
				// output register free, or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_valid_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside the response state");

	a_capture_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (cmd.act != ACT_CAPTURE))
		else $error("request captured while busy");

endmodule

// ===== rtl/bpa_datapath.sv =====
// Datapath of the bitmap page allocator: config registers, page map memory, count, result.
module bpa_datapath #(
	parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
	parameter int WORD_BITS  = bpa_pkg::DEF_WORD_BITS,
	parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [bpa_pkg::ADDR_W-1:0]        page_address,
	input  bpa_pkg::dp_cmd_t                  cmd,
	output bpa_pkg::dp_stat_t                 stat,
	output logic [bpa_pkg::ADDR_W-1:0]        result_address,
	output logic [bpa_pkg::STATUS_W-1:0]      status,
	output logic [bpa_pkg::COUNT_W-1:0]       free_count
);
	import bpa_pkg::*;

	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int IDX_W     = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);
	localparam int PB_W      = $clog2(MAP_WORDS * WORD_BITS + 1);
	// word index = (idx * DIV_M) >> DIV_K, exact for every IDX_W-bit index
	localparam int DIV_K     = IDX_W + BIT_W;
	localparam int DIV_M     = (2 ** DIV_K + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W    = IDX_W + DIV_K + 1;
	localparam logic [ADDR_W-1:0] WORD_SPAN = ADDR_W'(WORD_BITS) << PAGE_SHIFT;

	// configuration
	logic [ADDR_W-1:0]   base_q;
	logic [PCOUNT_W-1:0] pcount_q;
	logic [PCOUNT_W-1:0] resv_q;

	// map memory
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;
	logic                 rd_en;
	logic [MAP_AW-1:0]    rd_addr;
	logic                 wr_en;
	logic [MAP_AW-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// working registers
	logic [ADDR_W-1:0]   addr_q;
	logic [MAP_AW-1:0]   word_q;
	logic [PB_W-1:0]     page_base_q;
	logic [ADDR_W-1:0]   addr_base_q;
	logic [IDX_W-1:0]    idx_q;
	logic                oor_q;
	logic [MAP_AW-1:0]   q_q;
	logic [BIT_W-1:0]    bit_q;
	logic                res_take_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic [ADDR_W-1:0]   out_addr_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;

	// combinational
	logic [CNT_W-1:0]     n;
	logic [CNT_W-1:0]     init_cnt;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] iso;
	logic [BIT_W-1:0]     low_bit;
	logic                 bit_set;
	logic                 set_ok;
	logic [ADDR_W:0]      sub;
	logic [ADDR_W-1:0]    full_idx;
	logic [PROD_W-1:0]    prod;
	logic [31:0]          rem;
	logic [31:0]          pb32;
	logic [31:0]          lo_d;
	logic [31:0]          hi_d;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= RST_MEMORY_BASE;
			pcount_q <= RST_PAGE_COUNT;
			resv_q   <= RST_RESERVED_PAGES;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MEMORY_BASE:    base_q   <= ADDR_W'(cfg_data);
				CFG_PAGE_COUNT:     pcount_q <= PCOUNT_W'(cfg_data);
				CFG_RESERVED_PAGES: resv_q   <= PCOUNT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// managed pages, capped at the built capacity
	always_comb begin
		if (32'(pcount_q) > 32'(MAX_PAGES)) begin
			n = CNT_W'(MAX_PAGES);
		end else begin
			n = CNT_W'(pcount_q);
		end
		if (32'(n) > 32'(resv_q)) begin
			init_cnt = CNT_W'(32'(n) - 32'(resv_q));
		end else begin
			init_cnt = '0;
		end
	end

	// never-written words read as all allocated
	assign rd_word = rvld_q ? rdata_q : '0;
	assign bit_set = rd_word[bit_q];
	assign set_ok  = !oor_q && !bit_set;

	assign stat.word_hit  = |rd_word;
	assign stat.word_last = (word_q == MAP_AW'(MAP_WORDS - 1));

	// lowest free bit
	always_comb begin
		iso     = rd_word & (~rd_word + WORD_BITS'(1));
		low_bit = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				low_bit = low_bit | BIT_W'(i);
			end
		end
	end

	// init pattern: free from reserved_pages up to the managed count
	always_comb begin
		pb32 = 32'(page_base_q);
		lo_d = 32'(resv_q) - pb32;
		hi_d = 32'(n) - pb32;
		if (32'(resv_q) <= pb32) begin
			lo_mask = '1;
		end else if (lo_d >= 32'(WORD_BITS)) begin
			lo_mask = '0;
		end else begin
			lo_mask = {WORD_BITS{1'b1}} << lo_d[BIT_W-1:0];
		end
		if (32'(n) <= pb32) begin
			hi_mask = '0;
		end else if (hi_d >= 32'(WORD_BITS)) begin
			hi_mask = '1;
		end else begin
			hi_mask = ~({WORD_BITS{1'b1}} << hi_d[BIT_W-1:0]);
		end
	end

	// free address to page index, range check
	always_comb begin
		sub      = {1'b0, addr_q} - {1'b0, base_q};
		full_idx = sub[ADDR_W-1:0] >> PAGE_SHIFT;
		prod     = PROD_W'(idx_q) * PROD_W'(DIV_M);
		rem      = 32'(idx_q) - 32'(q_q) * 32'(WORD_BITS);
	end

	// memory port control
	always_comb begin
		rd_en   = (cmd.act == ACT_SCAN_RD) || (cmd.act == ACT_FREE_RD);
		rd_addr = (cmd.act == ACT_FREE_RD) ? q_q : word_q;
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = lo_mask & hi_mask;
		case (cmd.act)
			ACT_INIT_WORD: begin
				wr_en = 1'b1;
			end
			ACT_ALLOC_TAKE: begin
				wr_en   = 1'b1;
				wr_data = rd_word & ~iso;
			end
			ACT_FREE_UPD: begin
				wr_en   = set_ok;
				wr_addr = q_q;
				wr_data = rd_word | (WORD_BITS'(1) << bit_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	// free page count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.act)
				ACT_INIT_WORD: begin
					if (stat.word_last) begin
						cnt_q <= init_cnt;
					end
				end
				ACT_ALLOC_TAKE: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ACT_FREE_UPD: begin
					if (set_ok) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			ACT_CAPTURE: begin
				addr_q       <= page_address;
				word_q       <= '0;
				page_base_q  <= '0;
				addr_base_q  <= base_q;
				res_take_q   <= 1'b0;
				res_status_q <= ST_OK;
			end
			ACT_INIT_WORD: begin
				word_q      <= word_q + MAP_AW'(1);
				page_base_q <= page_base_q + PB_W'(WORD_BITS);
			end
			ACT_SCAN_NEXT: begin
				word_q      <= word_q + MAP_AW'(1);
				addr_base_q <= addr_base_q + WORD_SPAN;
			end
			ACT_ALLOC_TAKE: begin
				res_take_q <= 1'b1;
				bit_q      <= low_bit;
			end
			ACT_ALLOC_NONE: begin
				res_status_q <= ST_NONE_FREE;
			end
			ACT_FREE_SUB: begin
				oor_q <= sub[ADDR_W] || (32'(full_idx) >= 32'(n));
				idx_q <= IDX_W'(full_idx);
			end
			ACT_FREE_DIV: begin
				q_q <= MAP_AW'(prod >> DIV_K);
			end
			ACT_FREE_RD: begin
				bit_q <= BIT_W'(rem);
			end
			ACT_FREE_UPD: begin
				if (oor_q) begin
					res_status_q <= ST_OUT_OF_RANGE;
				end else if (bit_set) begin
					res_status_q <= ST_ALREADY_FREE;
				end
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_addr_q   <= res_take_q ? (addr_base_q + (ADDR_W'(bit_q) << PAGE_SHIFT)) : '0;
			out_status_q <= res_status_q;
			out_count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign result_address = out_addr_q;
	assign status         = out_status_q;
	assign free_count     = out_count_q;

	a_take_clears_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == ACT_ALLOC_TAKE) |-> ($countones(wr_data) == $countones(rd_word) - 1))
		else $error("allocation did not clear exactly one bit");

	a_free_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == ACT_FREE_UPD && set_ok) |=> (cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1))))
		else $error("successful free did not raise the count");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(MAX_PAGES))
		else $error("free count above capacity");

endmodule

// ===== rtl/bitmap_page_allocator_core.sv =====
// Top level of the bitmap page allocator: controller, datapath and channel hook-up.
//
// First-fit page frame allocator over a one-bit-per-page map (bit set = page free) held
// in a single-port memory of MAX_PAGES/WORD_BITS words, plus a free page count. Each
// request transfer carries an op: init (0) frees pages reserved_pages .. page_count-1 and
// marks every other page allocated; alloc (1) takes the lowest free page and answers
// memory_base + (index << PAGE_SHIFT); free (2) maps page_address back to an index and
// sets its bit; op 3 changes nothing. Every request gives exactly one response transfer
// with the address (zero unless an alloc succeeded), a status (ok, none free, already
// free, out of range) and the free count after the operation. A failed alloc or free
// changes nothing. Work is one request at a time, paced by the map memory's single
// port: init writes one map word per cycle; alloc reads and tests one word per scan
// step, up to the word holding the first free page (all MAP_WORDS words when none is
// free); free steps through range check, index split by a reciprocal multiply, read,
// update and respond. A finished response sits in an output register, so the next
// request is taken while it waits. After reset the map reads as all allocated without
// any clearing pass. The user must write configuration registers through
// cfg_we/cfg_idx/cfg_data only while the block is idle; the block itself does not
// enforce this.
module bitmap_page_allocator_core #(
	parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES,
	parameter int WORD_BITS  = bpa_pkg::DEF_WORD_BITS,
	parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bpa_req_if.sink                        req,
	bpa_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing: one request in flight, response held until transferred
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// map memory, count, address arithmetic and result register
	bpa_datapath #(
		.MAX_PAGES  (MAX_PAGES),
		.WORD_BITS  (WORD_BITS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.page_address   (req.page_address),
		.cmd            (cmd),
		.stat           (stat),
		.result_address (rsp.result_address),
		.status         (rsp.status),
		.free_count     (rsp.free_count)
	);

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the bitmap page allocator core.
`timescale 1ns / 1ps

module tb_top;
	import bpa_pkg::*;

	// Build of the block under test (defaults)
	localparam int MAX_PAGES  = DEF_MAX_PAGES;
	localparam int PAGE_SHIFT = DEF_PAGE_SHIFT;

	// The package names three ops; the fourth code must change nothing
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	// Watchdog limit on the run, well above what the worst correct run needs
	localparam int CYCLE_LIMIT = 3000000;

	// One response transfer as the allocator should produce it
	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} page_outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	bitmap_page_allocator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Shadow of the allocator: page map (bit set = free), free count and registers
	logic [MAX_PAGES-1:0] free_bits;
	int unsigned          free_total;
	logic [ADDR_W-1:0]    cfg_base;
	logic [PCOUNT_W-1:0]  cfg_pages;
	logic [PCOUNT_W-1:0]  cfg_reserved;

	// Responses still owed by the block, oldest first
	page_outcome_t outcome_q[$];
	// Page indices handed out by alloc and not yet given back; feeds well-formed frees
	int unsigned   held_pages[$];

	// Idling knobs, in percent per cycle, plus a counted receiver hold-off
	int req_gap_pct;
	int rsp_stall_pct;
	int rsp_hold_left;

	int err_count;
	int sent_count;
	int checked_count;
	int cfg_writes;
	int cycle_count;
	int status_tally[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Number of pages actually managed: page_count saturates at the built capacity
	function automatic int unsigned managed_pages();
		return (cfg_pages > MAX_PAGES) ? MAX_PAGES : int'(cfg_pages);
	endfunction

	// Applies one accepted request to the shadow map and queues the response it owes
	function automatic void predict_page_op(input logic [OP_W-1:0] op_v,
		input logic [ADDR_W-1:0] addr_v);
		page_outcome_t     o;
		int unsigned       n;
		int unsigned       idx;
		logic [ADDR_W-1:0] offs;
		bit                found;
		o.addr   = '0;
		o.status = ST_OK;
		n        = managed_pages();
		found    = 1'b0;
		case (op_v)
			OP_INIT: begin
				free_bits  = '0;
				free_total = 0;
				held_pages.delete();
				for (int p = int'(cfg_reserved); p < int'(n); p++) begin
					free_bits[p] = 1'b1;
					free_total++;
				end
			end
			OP_ALLOC: begin
				// word-then-bit scan from bit 0 is simply the lowest set index
				for (int p = 0; p < MAX_PAGES && !found; p++) begin
					if (free_bits[p]) begin
						free_bits[p] = 1'b0;
						if (free_total > 0)
							free_total--;
						o.addr = cfg_base + (ADDR_W'(p) << PAGE_SHIFT);
						held_pages.push_back(p);
						found = 1'b1;
					end
				end
				if (!found)
					o.status = ST_NONE_FREE;
			end
			OP_FREE: begin
				if (addr_v < cfg_base) begin
					o.status = ST_OUT_OF_RANGE;
				end else begin
					offs = addr_v - cfg_base;
					idx  = offs >> PAGE_SHIFT;
					if (idx >= n)
						o.status = ST_OUT_OF_RANGE;
					else if (free_bits[idx])
						o.status = ST_ALREADY_FREE;
					else begin
						free_bits[idx] = 1'b1;
						free_total++;
					end
				end
			end
			default: begin
				// unknown op: no change, plain ok
			end
		endcase
		o.count = COUNT_W'(free_total);
		outcome_q.push_back(o);
	endfunction

	// One request transfer, with random idle cycles ahead of it. Valid is left high
	// afterwards so that back-to-back transfers never toggle it within one step.
	task automatic send_op(input logic [OP_W-1:0] op_v, input logic [ADDR_W-1:0] addr_v);
		while ($urandom_range(99) < req_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op_v;
		req_ch.page_address <= addr_v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_page_op(op_v, addr_v);
		sent_count++;
	endtask

	// Sender stops and waits until every owed response has come back; block is idle
	task automatic drain_outcomes();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Writes all three registers back to back, write enable held high throughout.
	// Only called with the block idle.
	task automatic apply_layout(input logic [CFG_DATA_W-1:0] base_v,
		input logic [CFG_DATA_W-1:0] pages_v, input logic [CFG_DATA_W-1:0] reserved_v);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_MEMORY_BASE;
		cfg_data <= base_v;
		@(posedge clk);
		cfg_idx  <= CFG_PAGE_COUNT;
		cfg_data <= pages_v;
		@(posedge clk);
		cfg_idx  <= CFG_RESERVED_PAGES;
		cfg_data <= reserved_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		// registers are only as wide as the block keeps them
		cfg_base     = base_v;
		cfg_pages    = pages_v[PCOUNT_W-1:0];
		cfg_reserved = reserved_v[PCOUNT_W-1:0];
		cfg_writes  += 3;
	endtask

	// Compares one response transfer with the oldest owed response
	task automatic check_outcome();
		page_outcome_t want;
		if (outcome_q.size() == 0) begin
			err_count++;
			$display("%0t: response with none owed: addr %h status %0d count %0d",
				$time, rsp_ch.result_address, rsp_ch.status, rsp_ch.free_count);
		end else begin
			want = outcome_q.pop_front();
			checked_count++;
			status_tally[rsp_ch.status]++;
			if (rsp_ch.result_address !== want.addr) begin
				err_count++;
				$display("%0t: result_address expected %h, got %h",
					$time, want.addr, rsp_ch.result_address);
			end
			if (rsp_ch.status !== want.status) begin
				err_count++;
				$display("%0t: status expected %0d, got %0d",
					$time, want.status, rsp_ch.status);
			end
			if (rsp_ch.free_count !== want.count) begin
				err_count++;
				$display("%0t: free_count expected %0d, got %0d",
					$time, want.count, rsp_ch.free_count);
			end
		end
	endtask

	// Receiver: checks each response transfer, then decides ready for the next cycle.
	// A pending hold-off wins over the random stall.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				check_outcome();
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles, %0d responses still owed",
			$time, CYCLE_LIMIT, outcome_q.size());
		$display("TEST FAILED");
		$finish;
	end

	// One random item: mostly allocs and well-formed frees of pages held, the rest
	// stray, unaligned, below-base and beyond-range frees, occasional init and op 3
	task automatic random_op();
		int                r;
		int unsigned       n;
		int unsigned       pick;
		int unsigned       idx;
		logic [ADDR_W-1:0] a;
		r = $urandom_range(99);
		n = managed_pages();
		a = $urandom;
		if (r < 2) begin
			send_op(OP_INIT, a);
		end else if (r < 5) begin
			send_op(OP_NOP, a);
		end else if (r < 50) begin
			send_op(OP_ALLOC, a);
		end else begin
			r = $urandom_range(99);
			if (r < 65 && held_pages.size() > 0) begin
				pick = $urandom_range(held_pages.size() - 1);
				idx  = held_pages[pick];
				held_pages.delete(pick);
				a = cfg_base + (idx << PAGE_SHIFT);
				if ($urandom_range(7) == 0)
					a = a + $urandom_range(4095);
			end else if (r < 82) begin
				// any page up to one past the end: already free, reserved or out of range
				a = cfg_base + ($urandom_range(n) << PAGE_SHIFT) + $urandom_range(4095);
			end else if (r < 90) begin
				a = cfg_base - $urandom_range(1, 8192);
			end
			send_op(OP_FREE, a);
		end
	endtask

	// Random map layout: mostly small maps so that allocs run dry, some full maps with
	// a big reservation so that the scan goes deep, and oversized counts now and then
	task automatic random_layout();
		int unsigned       pages_v;
		int unsigned       res_v;
		logic [ADDR_W-1:0] base_v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: pages_v = $urandom_range(1, 160);
			5:             pages_v = $urandom_range(161, 4095);
			6, 7:          pages_v = MAX_PAGES;
			default:       pages_v = $urandom_range(MAX_PAGES + 1, 8191);
		endcase
		if (pages_v >= MAX_PAGES && $urandom_range(1) == 1)
			res_v = MAX_PAGES - $urandom_range(8, 200);
		else if (pages_v > MAX_PAGES)
			res_v = $urandom_range(0, 64);
		else
			res_v = $urandom_range(0, pages_v / 4);
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: base_v = {20'($urandom_range(0, 20'hFFFFF)), 12'h000};
			6:                base_v = '0;
			7:                base_v = 32'hFFFF_F000 - ($urandom_range(0, 15) << PAGE_SHIFT);
			8:                base_v = $urandom;
			default:          base_v = 32'hFFFF_FFFF;
		endcase
		apply_layout(base_v, pages_v, res_v);
	endtask

	// After reset the map is all allocated and the registers hold their defaults
	task automatic test_reset_state();
		req_gap_pct   = 0;
		rsp_stall_pct = 0;
		send_op(OP_ALLOC, 32'h0000_0000);  // alloc before init: none free
		send_op(OP_FREE, 32'h0000_0ABC);   // unaligned free of page 0, before init
		send_op(OP_ALLOC, 32'hFFFF_FFFF);  // hands page 0 straight back
		send_op(OP_NOP, 32'hFFFF_FFFF);
		send_op(OP_INIT, 32'h0000_0000);   // default reservation of 32 pages
		send_op(OP_ALLOC, 32'h0000_0000);
		send_op(OP_FREE, 32'h0000_5000);   // reserved page given back
		send_op(OP_FREE, 32'h0000_5000);   // now already free
		send_op(OP_ALLOC, 32'h0000_0000);  // reserved page is allocatable again
		send_op(OP_FREE, 32'hFFFF_FFFF);   // index far past the map
		send_op(OP_FREE, 32'h00FF_F000);   // last page, already free
		drain_outcomes();
	endtask

	// Register extremes: address wrap, oversized count and reservation, empty map,
	// count shrunk under an initialised map, garbage above the count's width
	task automatic test_register_extremes();
		apply_layout(32'hFFFF_F000, 32'd8191, 32'd4095);
		send_op(OP_INIT, 32'h0000_0000);   // one page left free, the top one
		send_op(OP_ALLOC, 32'h0000_0000);  // its address wraps past 2^32
		send_op(OP_ALLOC, 32'h0000_0000);  // nothing free
		send_op(OP_FREE, 32'h0000_0000);   // below the base
		send_op(OP_FREE, 32'hFFFF_F123);   // page 0, unaligned
		drain_outcomes();
		apply_layout(32'h0000_1000, 32'd0, 32'd0);
		send_op(OP_INIT, 32'h0000_0000);
		send_op(OP_FREE, 32'h0000_1000);   // no page is in range
		send_op(OP_ALLOC, 32'h0000_0000);
		drain_outcomes();
		apply_layout(32'h0000_1000, 32'd100, 32'd0);
		send_op(OP_INIT, 32'h0000_0000);
		drain_outcomes();
		apply_layout(32'h0000_1000, 32'd10, 32'd0);
		send_op(OP_ALLOC, 32'h0000_0000);  // scan ignores the shrunk count
		send_op(OP_FREE, 32'h0003_3000);   // page 50, now out of range
		drain_outcomes();
		apply_layout(32'h0000_0000, 32'd4096, 32'd8191);
		send_op(OP_INIT, 32'h0000_0000);   // reservation covers the whole map
		drain_outcomes();
		apply_layout(32'h0000_1000, 32'hABCD_E040, 32'hFFFF_E000);
		send_op(OP_INIT, 32'h0000_0000);   // count keeps only its low 13 bits: 64
		send_op(OP_ALLOC, 32'h0000_0000);
		drain_outcomes();
	endtask

	// Receiver holds off for a long counted stretch while requests keep coming, so the
	// block fills and drops ready; then the sender pauses until every response is in
	task automatic test_back_pressure();
		req_gap_pct   = 0;
		rsp_stall_pct = 0;
		apply_layout({20'($urandom_range(0, 20'hFFFFF)), 12'h000}, 32'd256, 32'd0);
		send_op(OP_INIT, 32'h0000_0000);
		rsp_hold_left = 400;
		repeat (16)
			send_op(OP_ALLOC, $urandom);
		drain_outcomes();
		repeat (20)
			random_op();
		drain_outcomes();
	endtask

	// One idling mode: two random layouts, each initialised and then hammered
	task automatic test_random_traffic(input int gap_pct, input int stall_pct);
		req_gap_pct   = gap_pct;
		rsp_stall_pct = stall_pct;
		repeat (2) begin
			drain_outcomes();
			random_layout();
			send_op(OP_INIT, $urandom);
			repeat (160)
				random_op();
		end
		drain_outcomes();
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_INIT;
		req_ch.page_address <= '0;
		cfg_we              <= 1'b0;
		cfg_idx             <= CFG_MEMORY_BASE;
		cfg_data            <= '0;
		free_bits           = '0;
		free_total          = 0;
		cfg_base            = RST_MEMORY_BASE;
		cfg_pages           = RST_PAGE_COUNT;
		cfg_reserved        = RST_RESERVED_PAGES;
		req_gap_pct         = 0;
		rsp_stall_pct       = 0;
		rsp_hold_left       = 0;
		err_count           = 0;
		sent_count          = 0;
		checked_count       = 0;
		cfg_writes          = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_extremes();
		test_random_traffic(0, 0);
		test_random_traffic(64, 0);
		test_random_traffic(0, 64);
		test_random_traffic(28, 28);
		test_back_pressure();
		test_random_traffic(0, 0);

		drain_outcomes();
		// a stray extra response would show up in this window
		repeat (300) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses, %0d register writes.",
			sent_count, checked_count, cfg_writes);
		$display("Status mix: ok %0d, none free %0d, already free %0d, out of range %0d.",
			status_tally[ST_OK], status_tally[ST_NONE_FREE], status_tally[ST_ALREADY_FREE],
			status_tally[ST_OUT_OF_RANGE]);
		if (err_count == 0 && outcome_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d responses never came", err_count, outcome_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator_core.sv
test/tb_top.sv
